[hdl/chm_pkg.sv]
package chm_pkg;

  localparam int KEY_W    = 31;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } out_t;

endpackage

[hdl/coalesced_hash_table_top.sv]
// Coalesced-chaining hash table of 31-bit keys with TABLE_SIZE slots.
// An input word (operation, key) is taken when start is high and busy is
// low. Operation insert stores the key, find looks it up. Exactly one result
// word follows each input word: out_valid is high for one cycle with status
// and slot on out_data. The receiver cannot stall, so every result is taken.
// Each word is handled in steps: the modulo unit reduces the key to its home
// slot (a reciprocal multiplication and one correction), the home slot is
// read from the slot memory, then the chain is followed one step per cycle.
// An insert that must search then scans the slots from the chain tail, the
// tail included, one slot per cycle, and last links the new slot from the tail.
// Only one word is in work at a time; busy falls in the cycle of the result
// strobe, so the next word can be taken at the edge that ends it.
// After reset the block clears all TABLE_SIZE slots of the slot memory, one
// slot a cycle, with busy high; no word is accepted during that pass.
module coalesced_hash_table_top #(
  parameter int TABLE_SIZE = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  chm_pkg::in_t  in_data,
  output logic          out_valid,
  output chm_pkg::out_t out_data
);

  localparam int IDXW = $clog2(TABLE_SIZE);
  localparam int KW   = chm_pkg::KEY_W;
  localparam int EW   = 2 + IDXW + KW;
  localparam int SW   = chm_pkg::SLOT_W;
  localparam logic [IDXW-1:0] LAST = IDXW'(TABLE_SIZE - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [IDXW-1:0] pos_r, pos_nxt;
  logic [IDXW-1:0] step_r, step_nxt;
  logic [IDXW-1:0] tail_r, tail_nxt;
  logic [IDXW-1:0] new_r, new_nxt;
  logic [EW-1:0]   tail_ent_r, tail_ent_nxt;
  logic            op_r, op_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic            ov_r, ov_nxt;
  chm_pkg::out_t   out_r, out_nxt;

  logic            mod_start, mod_done;
  logic [IDXW-1:0] mod_rem;

  logic            we;
  logic [IDXW-1:0] waddr;
  logic [EW-1:0]   wdata;
  logic [EW-1:0]   rdata;
  logic [EW-1:0]   store_ent;
  logic [EW-1:0]   link_base;

  logic            ent_used, ent_lv, ent_match;
  logic [IDXW-1:0] ent_link;

  assign ent_used  = rdata[EW-1];
  assign ent_lv    = rdata[EW-2];
  assign ent_link  = rdata[EW-3 -: IDXW];
  assign ent_match = (rdata[KW-1:0] == key_r);
  assign store_ent = {1'b1, 1'b0, {IDXW{1'b0}}, key_r};
  assign link_base = (new_r == tail_r) ? store_ent : tail_ent_r;

  chm_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_data.key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  chm_mem #(.DEPTH(TABLE_SIZE), .DW(EW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pos_nxt),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    step_nxt     = step_r;
    tail_nxt     = tail_r;
    new_nxt      = new_r;
    tail_ent_nxt = tail_ent_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    ov_nxt       = 1'b0;
    out_nxt      = out_r;
    mod_start    = 1'b0;
    we           = 1'b0;
    waddr        = pos_r;
    wdata        = store_ent;
    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        wdata   = '0;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == LAST) begin
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_data.operation;
          key_nxt   = in_data.key;
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_nxt   = mod_rem;
          step_nxt  = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (op_r == chm_pkg::OP_FIND) begin
          if (ent_used && ent_match) begin
            ov_nxt    = 1'b1;
            out_nxt   = '{status: chm_pkg::ST_FOUND, slot: SW'(pos_r)};
            state_nxt = S_IDLE;
          end else if (!ent_used || !ent_lv || step_r == LAST) begin
            ov_nxt    = 1'b1;
            out_nxt   = '{status: chm_pkg::ST_NOT_FOUND, slot: '0};
            state_nxt = S_IDLE;
          end else begin
            pos_nxt  = ent_link;
            step_nxt = step_r + 1'b1;
          end
        end else begin
          if (step_r == '0 && !ent_used) begin
            we        = 1'b1;
            ov_nxt    = 1'b1;
            out_nxt   = '{status: chm_pkg::ST_INSERTED, slot: SW'(pos_r)};
            state_nxt = S_IDLE;
          end else if (ent_used && ent_match) begin
            ov_nxt    = 1'b1;
            out_nxt   = '{status: chm_pkg::ST_DUPLICATE, slot: SW'(pos_r)};
            state_nxt = S_IDLE;
          end else if (!ent_lv) begin
            tail_nxt  = pos_r;
            step_nxt  = '0;
            state_nxt = S_SCAN;
          end else if (step_r == LAST) begin
            tail_nxt  = ent_link;
            pos_nxt   = ent_link;
            step_nxt  = '0;
            state_nxt = S_SCAN;
          end else begin
            pos_nxt  = ent_link;
            step_nxt = step_r + 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (step_r == '0) begin
          tail_ent_nxt = rdata;
        end
        if (!ent_used) begin
          we        = 1'b1;
          new_nxt   = pos_r;
          state_nxt = S_LINK;
        end else if (step_r == LAST) begin
          ov_nxt    = 1'b1;
          out_nxt   = '{status: chm_pkg::ST_FULL, slot: '0};
          state_nxt = S_IDLE;
        end else begin
          pos_nxt  = (pos_r == LAST) ? '0 : pos_r + 1'b1;
          step_nxt = step_r + 1'b1;
        end
      end
      S_LINK: begin
        we        = 1'b1;
        waddr     = tail_r;
        wdata     = {link_base[EW-1], 1'b1, new_r, link_base[KW-1:0]};
        ov_nxt    = 1'b1;
        out_nxt   = '{status: chm_pkg::ST_INSERTED, slot: SW'(new_r)};
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pos_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ov_r    <= ov_nxt;
    end
    step_r     <= step_nxt;
    tail_r     <= tail_nxt;
    new_r      <= new_nxt;
    tail_ent_r <= tail_ent_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

[hdl/chm_mod.sv]
module chm_mod #(
  parameter int TABLE_SIZE = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [chm_pkg::KEY_W-1:0]       key,
  output logic                            done,
  output logic [$clog2(TABLE_SIZE)-1:0]   rem
);

  localparam int IDXW = $clog2(TABLE_SIZE);
  localparam int RW   = IDXW + 1;
  localparam int KW   = chm_pkg::KEY_W;
  localparam int PW   = KW + 32;
  localparam logic [RW-1:0] N   = RW'(TABLE_SIZE);
  localparam logic [31:0]   MUL = 32'((64'd1 << 32) / TABLE_SIZE);

  logic          mul_r, mul_nxt;
  logic          fix_r, fix_nxt;
  logic          done_r, done_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [KW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] prod;
  logic [RW-1:0] diff;

  // The estimated quotient is exact or one short, so one subtraction fixes it.
  assign prod = PW'(key_r) * PW'(MUL);
  assign diff = key_r[RW-1:0] - quo_r[RW-1:0] * N;

  always_comb begin
    mul_nxt  = 1'b0;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    key_nxt  = key_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      mul_nxt = 1'b1;
      key_nxt = key;
    end
    if (mul_r) begin
      quo_nxt = prod[PW-1:32];
      fix_nxt = 1'b1;
    end
    if (fix_r) begin
      rem_nxt  = (diff >= N) ? diff - N : diff;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
    key_r <= key_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[IDXW-1:0];

endmodule

[hdl/chm_mem.sv]
module chm_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/chm_checker.sv]
module chm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input chm_pkg::in_t  in_data,
  input logic          out_valid,
  input chm_pkg::out_t out_data
);

  // The clearing pass after reset keeps the block busy.
  a_clear_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not hold the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == chm_pkg::ST_FULL ||
                   out_data.status == chm_pkg::ST_NOT_FOUND))
    |-> (out_data.slot == '0))
    else $error("slot not zero for a result without a slot");

  a_find_status: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation == chm_pkg::OP_FIND) |=>
    !(out_valid && out_data.status == chm_pkg::ST_INSERTED))
    else $error("unexpected insert status");

endmodule

bind coalesced_hash_table_top chm_checker u_chm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_SIZE = 64;
  localparam int WORD_COUNT = 800;
  localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 72;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  chm_pkg::in_t in_data;
  logic out_valid;
  chm_pkg::out_t out_data;

  logic [chm_pkg::KEY_W-1:0] held_key [TABLE_SIZE];
  bit slot_in_use [TABLE_SIZE];
  int next_slot [TABLE_SIZE];
  bit has_next [TABLE_SIZE];
  int slots_taken;
  logic [chm_pkg::KEY_W-1:0] stored_keys [$];

  chm_pkg::out_t expected_replies [$];
  chm_pkg::out_t want;
  int status_seen [5];
  int words_sent;
  int mismatches;
  int cycle_count;
  int steady_run;

  coalesced_hash_table_top #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void store_key(int pos, logic [chm_pkg::KEY_W-1:0] k);
    held_key[pos] = k;
    slot_in_use[pos] = 1'b1;
    has_next[pos] = 1'b0;
    next_slot[pos] = 0;
    slots_taken++;
    stored_keys.push_back(k);
  endfunction

  function automatic chm_pkg::out_t lookup_or_insert(chm_pkg::in_t word);
    chm_pkg::out_t res;
    logic [chm_pkg::KEY_W-1:0] k;
    int pos;
    int tail;
    int free_slot;
    bit done;
    k = word.key;
    pos = int'(k % TABLE_SIZE);
    res = '0;
    done = 1'b0;
    if (word.operation == chm_pkg::OP_FIND) begin
      res.status = chm_pkg::ST_NOT_FOUND;
      for (int steps = 0; steps < TABLE_SIZE; steps++) begin
        if (!slot_in_use[pos]) break;
        if (held_key[pos] == k) begin
          res.status = chm_pkg::ST_FOUND;
          res.slot = pos[chm_pkg::SLOT_W-1:0];
          break;
        end
        if (!has_next[pos]) break;
        pos = next_slot[pos];
      end
    end else if (!slot_in_use[pos]) begin
      store_key(pos, k);
      res.status = chm_pkg::ST_INSERTED;
      res.slot = pos[chm_pkg::SLOT_W-1:0];
    end else begin
      tail = pos;
      for (int steps = 0; steps < TABLE_SIZE; steps++) begin
        if (slot_in_use[tail] && held_key[tail] == k) begin
          res.status = chm_pkg::ST_DUPLICATE;
          res.slot = tail[chm_pkg::SLOT_W-1:0];
          done = 1'b1;
          break;
        end
        if (!has_next[tail]) break;
        tail = next_slot[tail];
      end
      if (!done) begin
        free_slot = -1;
        for (int i = tail; i < TABLE_SIZE; i++) begin
          if (!slot_in_use[i]) begin
            free_slot = i;
            break;
          end
        end
        if (free_slot < 0) begin
          for (int i = 0; i < tail; i++) begin
            if (!slot_in_use[i]) begin
              free_slot = i;
              break;
            end
          end
        end
        if (free_slot >= 0) begin
          store_key(free_slot, k);
          next_slot[tail] = free_slot;
          has_next[tail] = 1'b1;
          res.status = chm_pkg::ST_INSERTED;
          res.slot = free_slot[chm_pkg::SLOT_W-1:0];
        end else begin
          res.status = chm_pkg::ST_FULL;
          res.slot = '0;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [chm_pkg::KEY_W-1:0] random_key();
    bit [31:0] raw;
    logic [chm_pkg::KEY_W-1:0] k;
    int h;
    raw = $urandom;
    k = raw[chm_pkg::KEY_W-1:0];
    case ($urandom_range(0, 15))
      0: begin
        k[chm_pkg::KEY_W-1:chm_pkg::SLOT_W] = '0;
      end
      1: begin
        k[chm_pkg::KEY_W-1:chm_pkg::SLOT_W] = '1;
      end
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      h = $urandom_range(0, 11);
      if (h >= 6) h = h + TABLE_SIZE - 12;
      k[chm_pkg::SLOT_W-1:0] = h[chm_pkg::SLOT_W-1:0];
    end
    return k;
  endfunction

  function automatic logic [chm_pkg::KEY_W-1:0] known_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic send_word(input logic op, input logic [chm_pkg::KEY_W-1:0] key);
    chm_pkg::in_t word;
    int gap;
    bit wait_idle;
    word.operation = op;
    word.key = key;
    if (steady_run > 0) begin
      gap = 0;
      wait_idle = 1'b0;
      steady_run--;
    end else begin
      gap = $urandom_range(0, 16);
      wait_idle = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 31) == 0) steady_run = $urandom_range(10, 40);
    end
    if (gap > 0 || wait_idle) start <= 1'b0;
    if (wait_idle) begin
      do @(posedge clk); while (busy !== 1'b0);
    end
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_data <= word;
    do @(posedge clk); while (busy !== 1'b0);
    expected_replies.push_back(lookup_or_insert(word));
    words_sent++;
  endtask

  task automatic apply_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_empty_table();
    send_word(chm_pkg::OP_FIND, 31'd0);
    send_word(chm_pkg::OP_INSERT, 31'd0);
    send_word(chm_pkg::OP_INSERT, 31'd0);
    send_word(chm_pkg::OP_INSERT, 31'd64);
    send_word(chm_pkg::OP_INSERT, 31'd1);
    send_word(chm_pkg::OP_FIND, 31'd1);
    send_word(chm_pkg::OP_FIND, 31'd64);
    send_word(chm_pkg::OP_FIND, 31'd128);
    send_word(chm_pkg::OP_INSERT, 31'h7fffffff);
    send_word(chm_pkg::OP_INSERT, 31'h7fffffbf);
    send_word(chm_pkg::OP_FIND, 31'h7fffffbf);
    send_word(chm_pkg::OP_FIND, 31'h7fffffff);
    send_word(chm_pkg::OP_FIND, 31'h40000000);
    send_word(chm_pkg::OP_INSERT, 31'h2aaaaaaa);
    send_word(chm_pkg::OP_FIND, 31'h2aaaaaaa);
  endtask

  task automatic test_fill_with_collisions();
    int pick;
    while (slots_taken < TABLE_SIZE) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_word(chm_pkg::OP_INSERT, random_key());
      else if (pick < 65) send_word(chm_pkg::OP_INSERT, known_key());
      else if (pick < 85) send_word(chm_pkg::OP_FIND, known_key());
      else send_word(chm_pkg::OP_FIND, random_key());
    end
  endtask

  task automatic test_full_table();
    int pick;
    while (words_sent < WORD_COUNT) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_word(chm_pkg::OP_INSERT, random_key());
      else if (pick < 50) send_word(chm_pkg::OP_INSERT, known_key());
      else if (pick < 80) send_word(chm_pkg::OP_FIND, known_key());
      else send_word(chm_pkg::OP_FIND, random_key());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result status %0d slot %0d with nothing pending",
                                  out_data.status, out_data.slot));
      end else begin
        want = expected_replies.pop_front();
        if (want.status <= chm_pkg::ST_NOT_FOUND) status_seen[want.status]++;
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data.status,
                                    want.status));
        if (out_data.slot !== want.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", out_data.slot, want.slot));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", expected_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cycle_count = 0;
    apply_reset();
    test_empty_table();
    test_fill_with_collisions();
    test_full_table();
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words; the table filled with colliding chains and then stayed full.",
             words_sent);
    $display("Results: %0d inserted, %0d duplicate, %0d full, %0d found, %0d not found.",
             status_seen[chm_pkg::ST_INSERTED], status_seen[chm_pkg::ST_DUPLICATE],
             status_seen[chm_pkg::ST_FULL], status_seen[chm_pkg::ST_FOUND],
             status_seen[chm_pkg::ST_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/chm_pkg.sv
hdl/chm_mod.sv
hdl/chm_mem.sv
hdl/coalesced_hash_table_top.sv
hdl/chm_checker.sv
bench/testbench.sv
